### rtl/core/mos_pkg.sv
// motor operation sequencer package: item codes and the result flag bundle
package mos_pkg;

  // item function codes
  localparam logic [1:0] FUNC_REQ   = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // single-bit result flags of one item
  typedef struct packed {
    logic rejected;
    logic drive_valid;
    logic init_event;
    logic before_run_event;
    logic finish_event;
    logic status_match;
  } evt_t;

endpackage

### rtl/core/motor_operation_sequencer.sv
// motor operation sequencer: input register, phase machine and result register
//
// Input channel (in_*): one item per handshake, accepted when in_valid is
// high and in_stall low. func 0 requests an operation, 1 ticks the phase
// machine one step, 2 queries idle status against a given operation.
// Result channel (out_*): exactly one result item per input item, in order,
// carrying the event flags, the drive command, the phase after the item and
// the last completed operation.
// Each accepted item passes through the input register and then the result
// register; one item is taken every cycle as long as the result side keeps
// out_stall low. The phase update is combinational between the two registers.
// When out_stall is held, the result register holds its item, the input
// register fills, and in_stall rises one item later; nothing is dropped.
// Synchronous active-low reset empties both registers and puts the phase
// machine in init with current, pending and last operation cleared.
module motor_operation_sequencer #(
  parameter int OP_BITS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [OP_BITS-1:0] in_operation,
  input  logic               in_forced,
  input  logic               in_banned,
  input  logic               in_run_done,
  input  logic               in_stop_met,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_rejected,
  output logic               out_drive_valid,
  output logic [OP_BITS-1:0] out_drive_operation,
  output logic               out_init_event,
  output logic               out_before_run_event,
  output logic               out_finish_event,
  output logic               out_status_match,
  output logic [2:0]         out_phase,
  output logic [OP_BITS-1:0] out_last_operation
);
  import mos_pkg::*;

  logic               s1_vld_r;
  logic [1:0]         s1_func_r;
  logic [OP_BITS-1:0] s1_op_r;
  logic               s1_forced_r, s1_banned_r, s1_run_done_r, s1_stop_met_r;

  logic               out_vld_r;
  evt_t               out_evt_r;
  logic [OP_BITS-1:0] out_drive_op_r;
  logic [2:0]         out_phase_r;
  logic [OP_BITS-1:0] out_last_op_r;

  evt_t               evt;
  logic [OP_BITS-1:0] drive_op;
  logic [2:0]         phase_nxt;
  logic [OP_BITS-1:0] last_op_nxt;

  logic out_en, s1_en, step_en;

  // stage enables
  assign out_en   = !out_vld_r || !out_stall;
  assign s1_en    = !s1_vld_r || out_en;
  assign step_en  = s1_vld_r && out_en;
  assign in_stall = !s1_en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_func_r     <= in_func;
      s1_op_r       <= in_operation;
      s1_forced_r   <= in_forced;
      s1_banned_r   <= in_banned;
      s1_run_done_r <= in_run_done;
      s1_stop_met_r <= in_stop_met;
    end
  end

  mos_step #(
    .OP_BITS(OP_BITS)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .func       (s1_func_r),
    .op         (s1_op_r),
    .forced     (s1_forced_r),
    .banned     (s1_banned_r),
    .run_done   (s1_run_done_r),
    .stop_met   (s1_stop_met_r),
    .evt        (evt),
    .drive_op   (drive_op),
    .phase_nxt  (phase_nxt),
    .last_op_nxt(last_op_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_evt_r      <= evt;
      out_drive_op_r <= drive_op;
      out_phase_r    <= phase_nxt;
      out_last_op_r  <= last_op_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_rejected         = out_evt_r.rejected;
  assign out_drive_valid      = out_evt_r.drive_valid;
  assign out_drive_operation  = out_drive_op_r;
  assign out_init_event       = out_evt_r.init_event;
  assign out_before_run_event = out_evt_r.before_run_event;
  assign out_finish_event     = out_evt_r.finish_event;
  assign out_status_match     = out_evt_r.status_match;
  assign out_phase            = out_phase_r;
  assign out_last_operation   = out_last_op_r;

endmodule

### rtl/core/mos_step.sv
// motor operation sequencer phase machine: state registers and per-item next-state logic
module mos_step #(
  parameter int OP_BITS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [1:0]         func,
  input  logic [OP_BITS-1:0] op,
  input  logic               forced,
  input  logic               banned,
  input  logic               run_done,
  input  logic               stop_met,
  output mos_pkg::evt_t      evt,
  output logic [OP_BITS-1:0] drive_op,
  output logic [2:0]         phase_nxt,
  output logic [OP_BITS-1:0] last_op_nxt
);
  import mos_pkg::*;

  typedef enum logic [2:0] {
    PH_INIT          = 3'd0,
    PH_IDLE          = 3'd1,
    PH_START         = 3'd2,
    PH_RUN           = 3'd3,
    PH_WAIT          = 3'd4,
    PH_BEFORE_FINISH = 3'd5,
    PH_FINISH        = 3'd6
  } phase_t;

  phase_t             phase_r, phase_n;
  logic [OP_BITS-1:0] cur_r, cur_nxt;
  logic [OP_BITS-1:0] pend_r, pend_nxt;
  logic [OP_BITS-1:0] done_r, done_nxt;

  // next state and result for the item in the input register
  always_comb begin
    phase_n  = phase_r;
    cur_nxt  = cur_r;
    pend_nxt = pend_r;
    done_nxt = done_r;
    evt      = '0;
    drive_op = '0;
    unique case (func)
      FUNC_REQ: begin
        if (!forced && banned) begin
          evt.rejected = 1'b1;
        end else if (forced) begin
          cur_nxt = op;
          phase_n = PH_START;
        end else begin
          pend_nxt = op;
        end
      end
      FUNC_TICK: begin
        unique case (phase_r)
          PH_INIT: begin
            evt.init_event = 1'b1;
            phase_n        = PH_IDLE;
          end
          PH_IDLE: begin
            if (pend_r != '0) begin
              pend_nxt = '0;
              if (!banned && pend_r != cur_r) begin
                cur_nxt = pend_r;
                phase_n = PH_START;
              end
            end
          end
          PH_START: begin
            if (cur_r == '0) begin
              phase_n = PH_IDLE;
            end else begin
              evt.before_run_event = 1'b1;
              evt.drive_valid      = 1'b1;
              drive_op             = cur_r;
              phase_n              = PH_RUN;
            end
          end
          PH_RUN: begin
            if (run_done) phase_n = PH_WAIT;
          end
          PH_WAIT: begin
            if (stop_met) phase_n = PH_BEFORE_FINISH;
          end
          PH_BEFORE_FINISH: begin
            // stop command to the driver
            evt.drive_valid = 1'b1;
            phase_n         = PH_FINISH;
          end
          PH_FINISH: begin
            done_nxt         = cur_r;
            cur_nxt          = '0;
            evt.finish_event = 1'b1;
            phase_n          = PH_IDLE;
          end
          default: begin
            phase_n = phase_r;
          end
        endcase
      end
      FUNC_QUERY: begin
        evt.status_match = (phase_r == PH_IDLE) && (done_r == op);
      end
      default: begin
        phase_n = phase_r;
      end
    endcase
  end

  assign phase_nxt   = phase_n;
  assign last_op_nxt = done_nxt;

  // phase and operation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INIT;
      cur_r   <= '0;
      pend_r  <= '0;
      done_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_n;
      cur_r   <= cur_nxt;
      pend_r  <= pend_nxt;
      done_r  <= done_nxt;
    end
  end

  // idle is only reached with no current operation
  a_idle_no_current: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> cur_r == '0)
    else $error("idle phase with a current operation");

  // a nonzero drive command always enters the run phase
  a_drive_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && evt.drive_valid && drive_op != '0 |-> phase_n == PH_RUN)
    else $error("drive command without entering run");

  // a finished operation lands in idle with the completed code recorded
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && evt.finish_event |=> phase_r == PH_IDLE && done_r == $past(cur_r))
    else $error("finish did not return to idle");

  // a refused request changes no state
  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && evt.rejected |=> phase_r == $past(phase_r) && cur_r == $past(cur_r)
      && pend_r == $past(pend_r))
    else $error("refused request changed state");

endmodule
